// File: design/almd_pkg.sv
package almd_pkg;

  // field and state widths
  localparam int SAMPLE_W   = 24;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int SUM_W      = 59;
  localparam int CNT_W      = 13;
  localparam int LEVEL_W    = 16;
  localparam int NCH_W      = 2;
  localparam int DECAY_W    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CHANNELS = 1'b0,
    CFG_DECAY_FACTOR = 1'b1
  } cfg_idx_e;

  localparam logic [NCH_W-1:0]   NCH_RESET   = 2'd2;
  localparam logic [NCH_W-1:0]   NCH_MONO    = 2'd1;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd53740;

  // saturation bounds
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // block queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // divider, log and level mapping
  localparam int DIV_W    = CNT_W + 1;
  localparam int EXP_W    = 6;
  localparam int FRAC_W   = 16;
  localparam int FCNT_W   = 4;
  localparam int MANT_W   = 32;
  localparam int YCNT_W   = 5;
  localparam int LOG_W    = EXP_W + FRAC_W;
  localparam int COEF_W   = 13;
  localparam int DBP_W    = LOG_W + COEF_W;
  localparam int DECP_W   = 2 * LEVEL_W;

  localparam logic [COEF_W-1:0] DB_COEF  = 13'd4110;
  localparam logic [LOG_W-1:0]  FULL_LOG = 22'(2 * (SAMPLE_W - 1) * 65536);
  localparam logic [EXP_W-1:0]  TOP_STEP = 6'(SUM_W - 1);

  // snapshot of one finished block
  typedef struct packed {
    logic [SUM_W-1:0] square_sum;
    logic [CNT_W-1:0] frame_count;
    logic             two_ch;
  } snap_t;

  // queue status seen by front and back
  typedef struct packed {
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

// File: design/almd_in_if.sv
interface almd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [almd_pkg::SAMPLE_W-1:0] sample_left;
  logic signed [almd_pkg::SAMPLE_W-1:0] sample_right;
  logic                                last_in_block;

  modport source (output valid, sample_left, sample_right, last_in_block, input ready);
  modport sink   (input valid, sample_left, sample_right, last_in_block, output ready);
endinterface

// File: design/almd_out_if.sv
interface almd_out_if;
  logic                         valid;
  logic                         ready;
  logic [almd_pkg::LEVEL_W-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

// File: design/almd_fifo.sv
module almd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  almd_pkg::snap_t      push_data_i,
  input  logic                 pop_i,
  output almd_pkg::snap_t      head_o,
  output almd_pkg::fifo_stat_t stat_o
);

  almd_pkg::snap_t                      mem_q [almd_pkg::FIFO_DEPTH];
  logic [almd_pkg::FIFO_PTR_W-1:0]      wr_ptr_q;
  logic [almd_pkg::FIFO_PTR_W-1:0]      rd_ptr_q;
  logic [almd_pkg::FIFO_CNT_W-1:0]      cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.count     = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < almd_pkg::FIFO_CNT_W'(almd_pkg::FIFO_DEPTH))
    else $error("block queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("block queue underflow");

endmodule

// File: design/almd_front.sv
module almd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  almd_in_if.sink              in_i,
  input  logic                 two_ch_i,
  input  almd_pkg::fifo_stat_t fifo_stat_i,
  output logic                 push_o,
  output almd_pkg::snap_t      push_data_o
);

  // exact square of a signed sample
  function automatic logic [almd_pkg::SQ_W-1:0] sample_sq(
    input logic signed [almd_pkg::SAMPLE_W-1:0] s
  );
    logic [almd_pkg::SAMPLE_W-1:0] mag;
    mag = s[almd_pkg::SAMPLE_W-1] ? (~s + 1'b1) : s;
    return mag * mag;
  endfunction

  logic                          accept;
  logic                          a_valid_q;
  logic                          a_last_q;
  logic [almd_pkg::SQ_W-1:0]     sq_l_q;
  logic [almd_pkg::SQ_W-1:0]     sq_r_q;
  logic [almd_pkg::SUM_W-1:0]    sum_q;
  logic [almd_pkg::CNT_W-1:0]    cnt_q;
  logic [almd_pkg::SUM_W:0]      sum_wide;
  logic [almd_pkg::SUM_W-1:0]    sum_d;
  logic [almd_pkg::CNT_W-1:0]    cnt_d;
  logic [almd_pkg::FIFO_CNT_W-1:0] used;

  // reserve a queue slot for a block end still in the square stage
  assign used     = fifo_stat_i.count + almd_pkg::FIFO_CNT_W'(a_last_q);
  assign in_i.ready = used < almd_pkg::FIFO_CNT_W'(almd_pkg::FIFO_DEPTH);
  assign accept   = in_i.valid && in_i.ready;

  // square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
    end else begin
      a_valid_q <= accept;
      a_last_q  <= accept && in_i.last_in_block;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_l_q <= sample_sq(in_i.sample_left);
      sq_r_q <= two_ch_i ? sample_sq(in_i.sample_right) : '0;
    end
  end

  // saturating accumulate and frame count
  always_comb begin
    sum_wide = {1'b0, sum_q} + (almd_pkg::SUM_W + 1)'(sq_l_q)
             + (almd_pkg::SUM_W + 1)'(sq_r_q);
    sum_d    = (sum_wide > {1'b0, almd_pkg::SUM_MAX}) ? almd_pkg::SUM_MAX
                                                      : sum_wide[almd_pkg::SUM_W-1:0];
    cnt_d    = (cnt_q == almd_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (a_valid_q) begin
      if (a_last_q) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

  // hand the finished block to the back end
  assign push_o                  = a_valid_q && a_last_q;
  assign push_data_o.square_sum  = sum_d;
  assign push_data_o.frame_count = cnt_d;
  assign push_data_o.two_ch      = two_ch_i;

endmodule

// File: design/almd_back.sv
module almd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  almd_pkg::fifo_stat_t             fifo_stat_i,
  input  almd_pkg::snap_t                  head_i,
  output logic                             pop_o,
  input  logic [almd_pkg::DECAY_W-1:0]     decay_i,
  almd_out_if.source                       out_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_NORM = 6'b000100,
    ST_LOG  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } back_state_e;

  back_state_e                        state_q;
  logic [almd_pkg::SUM_W-1:0]         dvd_q;
  logic [almd_pkg::DIV_W-1:0]         dvs_q;
  logic [almd_pkg::DIV_W-1:0]         rem_q;
  logic [almd_pkg::EXP_W-1:0]         step_q;
  logic [almd_pkg::EXP_W-1:0]         exp_q;
  logic                               found_q;
  logic                               lvl_zero_q;
  logic [almd_pkg::MANT_W-1:0]        y_q;
  logic [almd_pkg::YCNT_W-1:0]        ycnt_q;
  logic [almd_pkg::FRAC_W-1:0]        frac_q;
  logic [almd_pkg::FCNT_W-1:0]        fcnt_q;
  logic [almd_pkg::DBP_W-1:0]         db_prod_q;
  logic [almd_pkg::DECP_W-1:0]        dec_prod_q;
  logic                               sat_hi_q;
  logic [almd_pkg::LEVEL_W-1:0]       held_q;
  logic                               out_valid_q;
  logic [almd_pkg::LEVEL_W-1:0]       out_level_q;

  logic [almd_pkg::DIV_W:0]           rem_sh;
  logic [almd_pkg::DIV_W:0]           rem_sub;
  logic                               qbit;
  logic [almd_pkg::DIV_W-1:0]         rem_d;
  logic [almd_pkg::DIV_W-1:0]         dvs_d;
  logic [2*almd_pkg::MANT_W-1:0]      prod_sq;
  logic [almd_pkg::LOG_W-1:0]         lg;
  logic [almd_pkg::LOG_W-1:0]         diff;
  logic [almd_pkg::DBP_W:0]           d_wide;
  logic [almd_pkg::DBP_W-16:0]        d_val;
  logic [almd_pkg::LEVEL_W-1:0]       lvl;
  logic [almd_pkg::LEVEL_W-1:0]       decayed;
  logic [almd_pkg::LEVEL_W-1:0]       held_d;
  logic                               fin_fire;

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, dvd_q[almd_pkg::SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = rem_sh >= {1'b0, dvs_q};
    rem_d   = qbit ? rem_sub[almd_pkg::DIV_W-1:0] : rem_sh[almd_pkg::DIV_W-1:0];
    dvs_d   = head_i.two_ch ? {head_i.frame_count, 1'b0} : {1'b0, head_i.frame_count};
  end

  // mantissa squaring for the log fraction bits
  assign prod_sq = y_q * y_q;

  // dB mapping and peak hold
  always_comb begin
    lg      = {exp_q, frac_q};
    diff    = almd_pkg::FULL_LOG - lg;
    d_wide  = {1'b0, db_prod_q} + (almd_pkg::DBP_W + 1)'(16'hFFFF);
    d_val   = d_wide[almd_pkg::DBP_W:16];
    if (lvl_zero_q) begin
      lvl = '0;
    end else if (sat_hi_q) begin
      lvl = '1;
    end else if (d_val >= (almd_pkg::DBP_W - 15)'(16'hFFFF)) begin
      lvl = '0;
    end else begin
      lvl = 16'hFFFF - d_val[almd_pkg::LEVEL_W-1:0];
    end
    decayed = dec_prod_q[almd_pkg::DECP_W-1:almd_pkg::LEVEL_W];
    held_d  = (lvl > decayed) ? lvl : decayed;
  end

  assign pop_o    = (state_q == ST_IDLE) && fifo_stat_i.not_empty;
  assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= '0;
      step_q  <= '0;
      ycnt_q  <= '0;
      fcnt_q  <= '0;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (fifo_stat_i.not_empty) begin
            state_q <= (dvs_d == '0) ? ST_MUL : ST_DIV;
            step_q  <= almd_pkg::TOP_STEP;
            found_q <= 1'b0;
            ycnt_q  <= '0;
          end
        end
        ST_DIV: begin
          if (qbit && !found_q) begin
            found_q <= 1'b1;
          end else if (found_q && ycnt_q != '1) begin
            ycnt_q <= ycnt_q + 1'b1;
          end
          if (step_q == '0) begin
            state_q <= (found_q || qbit) ? ST_NORM : ST_MUL;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_NORM: begin
          if (ycnt_q == '1) begin
            state_q <= ST_LOG;
            fcnt_q  <= '1;
          end else begin
            ycnt_q <= ycnt_q + 1'b1;
          end
        end
        ST_LOG: begin
          if (fcnt_q == '0) begin
            state_q <= ST_MUL;
          end else begin
            fcnt_q <= fcnt_q - 1'b1;
          end
        end
        ST_MUL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_fire) begin
            held_q  <= held_d;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dvd_q      <= head_i.square_sum;
        dvs_q      <= dvs_d;
        rem_q      <= '0;
        frac_q     <= '0;
        lvl_zero_q <= (dvs_d == '0);
      end
      ST_DIV: begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[almd_pkg::SUM_W-2:0], 1'b0};
        if (qbit && !found_q) begin
          exp_q <= step_q;
          y_q   <= almd_pkg::MANT_W'(1);
        end else if (found_q && ycnt_q != '1) begin
          y_q <= {y_q[almd_pkg::MANT_W-2:0], qbit};
        end
        if (step_q == '0 && !found_q && !qbit) begin
          lvl_zero_q <= 1'b1;
        end
      end
      ST_NORM: begin
        if (ycnt_q != '1) begin
          y_q <= {y_q[almd_pkg::MANT_W-2:0], 1'b0};
        end
      end
      ST_LOG: begin
        y_q <= prod_sq[2*almd_pkg::MANT_W-1]
             ? prod_sq[2*almd_pkg::MANT_W-1:almd_pkg::MANT_W]
             : prod_sq[2*almd_pkg::MANT_W-2:almd_pkg::MANT_W-1];
        frac_q[fcnt_q] <= prod_sq[2*almd_pkg::MANT_W-1];
      end
      ST_MUL: begin
        db_prod_q  <= almd_pkg::DBP_W'(diff) * almd_pkg::DBP_W'(almd_pkg::DB_COEF);
        dec_prod_q <= held_q * decay_i;
        sat_hi_q   <= lg >= almd_pkg::FULL_LOG;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_level_q <= held_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.level = out_level_q;

  a_block_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_i.frame_count != '0)
    else $error("block end with zero frames");

  a_norm_after_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NORM |-> found_q)
    else $error("normalize without a leading quotient bit");

  a_mant_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOG |-> y_q[almd_pkg::MANT_W-1])
    else $error("log mantissa not normalized");

endmodule

// File: design/audio_level_meter_db_decay_unit.sv
// channel   | dir | transaction
// in_i      | in  | one stereo frame: sample_left, sample_right, last_in_block
// out_o     | out | held meter level, one per frame flagged last_in_block
// cfg_*_i   | in  | write of num_channels (index 0) or decay_factor (index 1)
//
// frames are taken one per cycle while in_i.ready is high; each frame is squared into
// the square stage register and then added into the accumulator. each block end is
// handled by the bit-serial back end in order: divide, normalize, log and map; a silent
// block skips normalize and log, and a stalled output holds the final map step.
// a four-deep block queue sits between; input stalls only when it is full,
// counting a block end still in the square stage.
// reset clears the accumulator, count, held level and restores the registers.
module audio_level_meter_db_decay_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  almd_in_if.sink                           in_i,
  almd_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [almd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [almd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic [almd_pkg::NCH_W-1:0]   num_ch_q;
  logic [almd_pkg::DECAY_W-1:0] decay_q;
  logic                         two_ch;
  logic                         push;
  logic                         pop;
  almd_pkg::snap_t              push_data;
  almd_pkg::snap_t              head;
  almd_pkg::fifo_stat_t         fifo_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q <= almd_pkg::NCH_RESET;
      decay_q  <= almd_pkg::DECAY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        almd_pkg::CFG_NUM_CHANNELS: num_ch_q <= cfg_wdata_i[almd_pkg::NCH_W-1:0];
        almd_pkg::CFG_DECAY_FACTOR: decay_q  <= cfg_wdata_i[almd_pkg::DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign two_ch = (num_ch_q != almd_pkg::NCH_MONO);

  almd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .two_ch_i    (two_ch),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  almd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  almd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .head_i      (head),
    .pop_o       (pop),
    .decay_i     (decay_q),
    .out_o       (out_o)
  );

endmodule
